// ===== hdl/ssi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_pkg : shared types and constants of the state-space integrator
// Transfer formats, store and register codes, controller commands and the
// saturation helper used by the datapath.
// ----------------------------------------------------------------------------
package ssi_pkg;

   // Default sizes, handed to the top level parameters
   localparam int MAX_STATES_DEF  = 8;
   localparam int MAX_INPUTS_DEF  = 4;
   localparam int MAX_OUTPUTS_DEF = 4;

   // Index and count widths, wide enough for the full parameter range
   localparam int IDX_W  = 4;   // row / column index, up to 16 states
   localparam int CNT_W  = 5;   // state count, up to 16
   localparam int TERM_W = 5;   // terms in one dot product, up to 20
   localparam int ACC_W  = 56;  // dot product accumulator
   localparam int PROD_W = 65;  // 32 x 33 signed product
   localparam int PSUM_W = 52;  // weighted sum of k * dt for one state
   localparam int DIV_W  = 36;  // dividend of the divide-by-six unit

   typedef struct packed {
      logic              action;
      logic [2:0]        target;
      logic [2:0]        row;
      logic [2:0]        column;
      logic signed [31:0] coefficient;
      logic signed [31:0] drive_0;
      logic signed [31:0] drive_1;
      logic signed [31:0] drive_2;
      logic signed [31:0] drive_3;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         output_index;
      logic signed [31:0] output_value;
      logic               last;
   } rsp_item_type;

   // Result kinds
   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_RANGE  = 2'd2;

   // Actions
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // Store codes of a write
   localparam logic [2:0] TGT_A = 3'd0;
   localparam logic [2:0] TGT_B = 3'd1;
   localparam logic [2:0] TGT_C = 3'd2;
   localparam logic [2:0] TGT_D = 3'd3;
   localparam logic [2:0] TGT_X = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] CSR_MODE    = 3'd0;
   localparam logic [2:0] CSR_DT      = 3'd1;
   localparam logic [2:0] CSR_STATES  = 3'd2;
   localparam logic [2:0] CSR_INPUTS  = 3'd3;
   localparam logic [2:0] CSR_OUTPUTS = 3'd4;

   typedef enum logic [2:0] {
      TERM_A,
      TERM_B,
      TERM_C,
      TERM_D,
      TERM_UPD
   } term_type;

   typedef enum logic [2:0] {
      UPD_EULER,
      UPD_RK1,
      UPD_RK2,
      UPD_RK3,
      UPD_RK4
   } upd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DERIV,
      ST_DRAIN_D,
      ST_UPD,
      ST_DRAIN_U,
      ST_DIV,
      ST_DIV_WAIT,
      ST_OUT,
      ST_DRAIN_O
   } ctrl_state_type;

   typedef struct packed {
      logic             issue;
      term_type         term;
      upd_type          upd;
      logic             trial;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             first;
      logic             fin;
      logic             out_last;
      logic             wr_elem;
      logic             load_drive;
      logic             div_start;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic div_done;
   } sts_type;

   localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ssi_div6.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_div6 : floor division by six
// Four quotient bits per cycle over the magnitude; floor for negative values.
// ----------------------------------------------------------------------------
module ssi_div6 (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [ssi_pkg::DIV_W-1:0]  dividend,
   output logic signed [ssi_pkg::DIV_W-1:0]       quotient,
   output logic                                   done
);
   import ssi_pkg::*;

   localparam int STEPS = DIV_W / 4;
   localparam int SC_W  = $clog2(STEPS + 1);

   logic [SC_W-1:0]    cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic [DIV_W-1:0]   mag_ff, mag_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [2:0]         rem_ff, rem_in;
   logic signed [DIV_W-1:0] q_ff, q_in;
   logic               done_ff, done_in;
   logic [3:0]         r;
   logic [3:0]         qbits;

   always_comb begin
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      r       = {1'b0, rem_ff};
      qbits   = '0;
      if (start) begin
         neg_in = dividend[DIV_W-1];
         // floor for negatives: -ceil(|w| / 6)
         mag_in = dividend[DIV_W-1] ? (DIV_W'(-dividend) + DIV_W'(5)) : dividend;
         quo_in = '0;
         rem_in = '0;
         cnt_in = SC_W'(STEPS);
      end else if (cnt_ff != '0) begin
         for (int b = 0; b < 4; b++) begin
            r = {r[2:0], mag_ff[DIV_W-1-b]};
            if (r >= 4'd6) begin
               r = r - 4'd6;
               qbits[3-b] = 1'b1;
            end
         end
         rem_in = r[2:0];
         mag_in = {mag_ff[DIV_W-5:0], 4'd0};
         quo_in = {quo_ff[DIV_W-5:0], qbits};
         cnt_in = cnt_ff - SC_W'(1);
         if (cnt_ff == SC_W'(1)) begin
            q_in    = neg_ff ? -$signed(quo_in) : $signed(quo_in);
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

// ===== hdl/ssi_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_ctrl : step sequencer
// Walks the derivative, update, divide and output passes, one term a cycle while a pass issues.
// ----------------------------------------------------------------------------
module ssi_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        action,
   input  wire logic                        mode,
   input  wire logic                        dt_zero,
   input  wire logic [ssi_pkg::CNT_W-1:0]   n_used,
   input  wire logic [2:0]                  m_used,
   input  wire logic [2:0]                  p_used,
   input  wire ssi_pkg::sts_type            sts,
   output ssi_pkg::cmd_type                 cmd,
   output logic                             busy
);
   import ssi_pkg::*;

   ctrl_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [TERM_W-1:0]  term_ff, term_in;
   logic [1:0]         stage_ff, stage_in;

   logic [TERM_W-1:0]  nterms;
   logic               last_term;
   logic               last_row_n;
   logic               last_row_p;
   logic               term_state;
   logic [IDX_W-1:0]   term_col;
   upd_type            upd_sel;

   assign nterms     = TERM_W'(n_used) + TERM_W'(m_used);
   assign last_term  = (term_ff == nterms - TERM_W'(1));
   assign last_row_n = (CNT_W'(row_ff) == n_used - CNT_W'(1));
   assign last_row_p = (CNT_W'(row_ff) == CNT_W'(p_used) - CNT_W'(1));
   assign term_state = (term_ff < TERM_W'(n_used));
   assign term_col   = term_state ? IDX_W'(term_ff) : IDX_W'(term_ff - TERM_W'(n_used));

   always_comb begin
      if (!mode) begin
         upd_sel = UPD_EULER;
      end else begin
         unique case (stage_ff)
            2'd0: upd_sel = UPD_RK1;
            2'd1: upd_sel = UPD_RK2;
            2'd2: upd_sel = UPD_RK3;
            2'd3: upd_sel = UPD_RK4;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && action == ACT_STEP) begin
               state_in = dt_zero ? ST_OUT : ST_DERIV;
            end
         end
         ST_DERIV: begin
            if (last_term && last_row_n) state_in = ST_DRAIN_D;
         end
         ST_DRAIN_D: begin
            if (!sts.pipe_busy) state_in = ST_UPD;
         end
         ST_UPD: begin
            if (last_row_n) state_in = ST_DRAIN_U;
         end
         ST_DRAIN_U: begin
            if (!sts.pipe_busy) begin
               if (!mode) begin
                  state_in = ST_OUT;
               end else if (stage_ff == 2'd3) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_DERIV;
               end
            end
         end
         ST_DIV: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (sts.div_done) state_in = last_row_n ? ST_OUT : ST_DIV;
         end
         ST_OUT: begin
            if (last_term && last_row_p) state_in = ST_DRAIN_O;
         end
         ST_DRAIN_O: begin
            if (!sts.pipe_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // row, term and stage counters
   always_comb begin
      row_in   = row_ff;
      term_in  = term_ff;
      stage_in = stage_ff;
      unique case (state_ff)
         ST_IDLE: begin
            row_in   = '0;
            term_in  = '0;
            stage_in = '0;
         end
         ST_DERIV, ST_OUT: begin
            if (last_term) begin
               term_in = '0;
               row_in  = ((state_ff == ST_DERIV && last_row_n) ||
                          (state_ff == ST_OUT && last_row_p)) ? '0 : row_ff + IDX_W'(1);
            end else begin
               term_in = term_ff + TERM_W'(1);
            end
         end
         ST_UPD: row_in = last_row_n ? '0 : row_ff + IDX_W'(1);
         ST_DRAIN_U: begin
            if (!sts.pipe_busy && mode && stage_ff != 2'd3) stage_in = stage_ff + 2'd1;
         end
         ST_DIV: ;  // hold the row while the divider starts
         ST_DIV_WAIT: begin
            if (sts.div_done) row_in = last_row_n ? '0 : row_ff + IDX_W'(1);
         end
         default: begin
            row_in  = '0;
            term_in = '0;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      cmd.row = row_ff;
      cmd.col = term_col;
      cmd.upd = upd_sel;
      cmd.trial = (stage_ff != 2'd0);
      cmd.first = (term_ff == '0);
      cmd.fin = last_term;
      cmd.out_last = last_row_p;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.wr_elem    = start && action == ACT_WRITE;
            cmd.load_drive = start && action == ACT_STEP;
         end
         ST_DERIV: begin
            cmd.issue = 1'b1;
            cmd.term  = term_state ? TERM_A : TERM_B;
         end
         ST_UPD: begin
            cmd.issue = 1'b1;
            cmd.term  = TERM_UPD;
         end
         ST_DIV: cmd.div_start = 1'b1;
         ST_OUT: begin
            cmd.issue = 1'b1;
            cmd.term  = term_state ? TERM_C : TERM_D;
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         term_ff  <= '0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         term_ff  <= term_in;
         stage_ff <= stage_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/ssi_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_dpath : stores and multiply-accumulate pipeline
// Operand fetch, multiply, then accumulate or state update; element writes.
// ----------------------------------------------------------------------------
module ssi_dpath #(
   parameter int MAX_STATES  = ssi_pkg::MAX_STATES_DEF,
   parameter int MAX_INPUTS  = ssi_pkg::MAX_INPUTS_DEF,
   parameter int MAX_OUTPUTS = ssi_pkg::MAX_OUTPUTS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ssi_pkg::cmd_type       cmd,
   input  wire ssi_pkg::req_item_type  req_item,
   input  wire logic [16:0]            dt,
   output ssi_pkg::sts_type            sts,
   output logic                        rsp_strobe,
   output ssi_pkg::rsp_item_type       rsp_item
);
   import ssi_pkg::*;

   localparam int SW     = (MAX_STATES > 1)  ? $clog2(MAX_STATES)  : 1;
   localparam int IW     = (MAX_INPUTS > 1)  ? $clog2(MAX_INPUTS)  : 1;
   localparam int OW     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int ADEPTH = MAX_STATES * MAX_STATES;
   localparam int AW     = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;

   // stores
   logic signed [31:0] a_mem [ADEPTH];
   logic [ADEPTH-1:0]  a_vld_ff;
   logic signed [31:0] a_rd_ff;
   logic               a_rv_ff;
   logic signed [31:0] b_ff [MAX_STATES][MAX_INPUTS];
   logic signed [31:0] c_ff [MAX_OUTPUTS][MAX_STATES];
   logic signed [31:0] d_ff [MAX_OUTPUTS][MAX_INPUTS];
   logic signed [31:0] x_ff [MAX_STATES];
   logic signed [31:0] xt_ff [MAX_STATES];
   logic signed [31:0] k_ff [MAX_STATES];
   logic signed [PSUM_W-1:0] p_ff [MAX_STATES];
   logic signed [31:0] u_ff [MAX_INPUTS];
   logic signed [31:0] drv [4];

   // element write decode
   logic [IDX_W-1:0]   w_row, w_col;
   logic               wr_a, wr_b, wr_c, wr_d, wr_x, wr_ok;
   logic [AW-1:0]      a_waddr, a_raddr;

   // pipeline
   logic signed [31:0] opa_in;
   logic signed [32:0] opb_in;
   logic               s1_vld_ff, s2_vld_ff;
   term_type           s1_term_ff, s2_term_ff;
   upd_type            s1_upd_ff, s2_upd_ff;
   logic [IDX_W-1:0]   s1_row_ff, s2_row_ff;
   logic               s1_first_ff, s2_first_ff;
   logic               s1_fin_ff, s2_fin_ff;
   logic               s1_olast_ff, s2_olast_ff;
   logic signed [31:0] s1_opa_ff;
   logic signed [32:0] s1_opb_ff;
   logic signed [31:0] opa_eff;
   logic signed [PROD_W-1:0] opa_x, opb_x, prod_in, prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_sum, term_x;
   logic signed [31:0] dot_sat;
   logic signed [63:0] x_old, sh16, sh17;
   logic signed [31:0] x_new16, x_new17;
   logic               s2_mac_fin;

   // divider
   logic signed [DIV_W-1:0] div_q;
   logic               div_done;
   logic [IDX_W-1:0]   div_row_ff;
   logic signed [DIV_W-1:0] div_w;
   logic signed [31:0] x_div;

   assign drv[0] = req_item.drive_0;
   assign drv[1] = req_item.drive_1;
   assign drv[2] = req_item.drive_2;
   assign drv[3] = req_item.drive_3;

   assign w_row = IDX_W'(req_item.row);
   assign w_col = IDX_W'(req_item.column);

   always_comb begin
      wr_a = 1'b0;
      wr_b = 1'b0;
      wr_c = 1'b0;
      wr_d = 1'b0;
      wr_x = 1'b0;
      unique case (req_item.target)
         TGT_A: wr_a = (32'(w_row) < 32'(MAX_STATES))  && (32'(w_col) < 32'(MAX_STATES));
         TGT_B: wr_b = (32'(w_row) < 32'(MAX_STATES))  && (32'(w_col) < 32'(MAX_INPUTS));
         TGT_C: wr_c = (32'(w_row) < 32'(MAX_OUTPUTS)) && (32'(w_col) < 32'(MAX_STATES));
         TGT_D: wr_d = (32'(w_row) < 32'(MAX_OUTPUTS)) && (32'(w_col) < 32'(MAX_INPUTS));
         TGT_X: wr_x = (32'(w_row) < 32'(MAX_STATES));
         default: ;
      endcase
      wr_ok = wr_a | wr_b | wr_c | wr_d | wr_x;
   end

   assign a_waddr = AW'(32'(w_row) * MAX_STATES + 32'(w_col));
   assign a_raddr = AW'(32'(cmd.row) * MAX_STATES + 32'(cmd.col));

   // system matrix memory; a cleared entry reads as zero until written
   always_ff @(posedge clock) begin
      if (cmd.wr_elem && wr_a) a_mem[a_waddr] <= req_item.coefficient;
   end

   always_ff @(posedge clock) begin
      a_rd_ff <= a_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         a_rv_ff  <= 1'b0;
      end else begin
         a_rv_ff <= a_vld_ff[a_raddr];
         if (cmd.wr_elem && wr_a) a_vld_ff[a_waddr] <= 1'b1;
      end
   end

   // operand fetch
   always_comb begin
      opa_in = '0;
      opb_in = '0;
      unique case (cmd.term)
         TERM_A: begin
            opb_in = cmd.trial ? 33'(xt_ff[cmd.col[SW-1:0]]) : 33'(x_ff[cmd.col[SW-1:0]]);
         end
         TERM_B: begin
            opa_in = b_ff[cmd.row[SW-1:0]][cmd.col[IW-1:0]];
            opb_in = 33'(u_ff[cmd.col[IW-1:0]]);
         end
         TERM_C: begin
            opa_in = c_ff[cmd.row[OW-1:0]][cmd.col[SW-1:0]];
            opb_in = 33'(x_ff[cmd.col[SW-1:0]]);
         end
         TERM_D: begin
            opa_in = d_ff[cmd.row[OW-1:0]][cmd.col[IW-1:0]];
            opb_in = 33'(u_ff[cmd.col[IW-1:0]]);
         end
         TERM_UPD: begin
            opa_in = k_ff[cmd.row[SW-1:0]];
            opb_in = $signed({16'd0, dt});
         end
         default: ;
      endcase
   end

   // multiply
   assign opa_eff = (s1_term_ff == TERM_A) ? (a_rv_ff ? a_rd_ff : 32'sd0) : s1_opa_ff;
   assign opa_x   = {{(PROD_W-32){opa_eff[31]}}, opa_eff};
   assign opb_x   = {{(PROD_W-33){s1_opb_ff[32]}}, s1_opb_ff};
   assign prod_in = opa_x * opb_x;

   // accumulate: each product truncated by floor to Q16.16
   assign term_x  = {{(ACC_W-49){prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:16]};
   assign acc_sum = (s2_first_ff ? '0 : acc_ff) + term_x;
   assign dot_sat = sat32({{(64-ACC_W){acc_sum[ACC_W-1]}}, acc_sum});

   // state update terms
   assign x_old   = {{32{x_ff[s2_row_ff[SW-1:0]][31]}}, x_ff[s2_row_ff[SW-1:0]]};
   assign sh16    = {{15{prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:16]};
   assign sh17    = {{16{prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:17]};
   assign x_new16 = sat32(x_old + sh16);
   assign x_new17 = sat32(x_old + sh17);

   assign s2_mac_fin = s2_vld_ff && s2_fin_ff && (s2_term_ff != TERM_UPD);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_term_ff  <= cmd.term;
      s1_upd_ff   <= cmd.upd;
      s1_row_ff   <= cmd.row;
      s1_first_ff <= cmd.first;
      s1_fin_ff   <= cmd.fin;
      s1_olast_ff <= cmd.out_last;
      s1_opa_ff   <= opa_in;
      s1_opb_ff   <= opb_in;
      s2_term_ff  <= s1_term_ff;
      s2_upd_ff   <= s1_upd_ff;
      s2_row_ff   <= s1_row_ff;
      s2_first_ff <= s1_first_ff;
      s2_fin_ff   <= s1_fin_ff;
      s2_olast_ff <= s1_olast_ff;
      prod_ff     <= prod_in;
      if (s2_vld_ff && s2_term_ff != TERM_UPD) acc_ff <= acc_sum;
   end

   // scratch: derivatives, trial state and weighted sums
   always_ff @(posedge clock) begin
      if (s2_mac_fin && (s2_term_ff == TERM_A || s2_term_ff == TERM_B)) begin
         k_ff[s2_row_ff[SW-1:0]] <= dot_sat;
      end
      if (s2_vld_ff && s2_term_ff == TERM_UPD) begin
         unique case (s2_upd_ff)
            UPD_RK1: begin
               xt_ff[s2_row_ff[SW-1:0]] <= x_new17;
               p_ff[s2_row_ff[SW-1:0]]  <= prod_ff[PSUM_W-1:0];
            end
            UPD_RK2: begin
               xt_ff[s2_row_ff[SW-1:0]] <= x_new17;
               p_ff[s2_row_ff[SW-1:0]]  <= p_ff[s2_row_ff[SW-1:0]] +
                                           {prod_ff[PSUM_W-2:0], 1'b0};
            end
            UPD_RK3: begin
               xt_ff[s2_row_ff[SW-1:0]] <= x_new16;
               p_ff[s2_row_ff[SW-1:0]]  <= p_ff[s2_row_ff[SW-1:0]] +
                                           {prod_ff[PSUM_W-2:0], 1'b0};
            end
            UPD_RK4: begin
               p_ff[s2_row_ff[SW-1:0]] <= p_ff[s2_row_ff[SW-1:0]] + prod_ff[PSUM_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // drives, latched as the step is taken
   always_ff @(posedge clock) begin
      if (cmd.load_drive) begin
         for (int i = 0; i < MAX_INPUTS; i++) u_ff[i] <= drv[i];
      end
   end

   // divide the weighted sum by six after the floor shift
   assign div_w = p_ff[cmd.row[SW-1:0]][PSUM_W-1:16];

   always_ff @(posedge clock) begin
      if (cmd.div_start) div_row_ff <= cmd.row;
   end

   ssi_div6 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_w),
      .quotient (div_q),
      .done     (div_done)
   );

   assign x_div = sat32({{32{x_ff[div_row_ff[SW-1:0]][31]}}, x_ff[div_row_ff[SW-1:0]]} +
                        {{(64-DIV_W){div_q[DIV_W-1]}}, div_q});

   // B, C, D matrices and state vector, all cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAX_STATES; r++) begin
            x_ff[r] <= '0;
            for (int c = 0; c < MAX_INPUTS; c++) b_ff[r][c] <= '0;
         end
         for (int r = 0; r < MAX_OUTPUTS; r++) begin
            for (int c = 0; c < MAX_STATES; c++) c_ff[r][c] <= '0;
            for (int c = 0; c < MAX_INPUTS; c++) d_ff[r][c] <= '0;
         end
      end else begin
         if (cmd.wr_elem && wr_b) b_ff[w_row[SW-1:0]][w_col[IW-1:0]] <= req_item.coefficient;
         if (cmd.wr_elem && wr_c) c_ff[w_row[OW-1:0]][w_col[SW-1:0]] <= req_item.coefficient;
         if (cmd.wr_elem && wr_d) d_ff[w_row[OW-1:0]][w_col[IW-1:0]] <= req_item.coefficient;
         if (cmd.wr_elem && wr_x) x_ff[w_row[SW-1:0]] <= req_item.coefficient;
         if (s2_vld_ff && s2_term_ff == TERM_UPD && s2_upd_ff == UPD_EULER) begin
            x_ff[s2_row_ff[SW-1:0]] <= x_new16;
         end
         if (div_done) x_ff[div_row_ff[SW-1:0]] <= x_div;
      end
   end

   // result register
   rsp_item_type rsp_ff, rsp_in;
   logic         rsp_strobe_ff, rsp_strobe_in;

   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      if (cmd.wr_elem) begin
         rsp_strobe_in       = 1'b1;
         rsp_in.kind         = wr_ok ? KIND_ACK : KIND_RANGE;
         rsp_in.output_index = '0;
         rsp_in.output_value = '0;
         rsp_in.last         = 1'b1;
      end else if (s2_mac_fin && (s2_term_ff == TERM_C || s2_term_ff == TERM_D)) begin
         rsp_strobe_in       = 1'b1;
         rsp_in.kind         = KIND_SAMPLE;
         rsp_in.output_index = s2_row_ff[1:0];
         rsp_in.output_value = dot_sat;
         rsp_in.last         = s2_olast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_item      = rsp_ff;
   assign sts.pipe_busy = s1_vld_ff | s2_vld_ff;
   assign sts.div_done  = div_done;

endmodule
`default_nettype wire

// ===== hdl/state_space_integrator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// state_space_integrator : linear state-space model, Euler or RK4 stepping
// Holds A, B, C, D and x in signed Q16.16, advances x one time step per
// step transfer and returns y = C*x + D*u for every output in use.
//
//   channel  ports                         handshake
//   request  start, busy, req_item         taken when start & !busy
//   result   rsp_strobe, rsp_item          one cycle per transfer, no stall
//   config   csr_valid, csr_ready, csr_*   taken when csr_valid & csr_ready
//
// A write is answered by a registered reply in the cycle after it is taken.
// A step runs on one shared multiply-accumulate pipe, one term a cycle
// while a pass is issuing; the sequencer waits for the pipe to drain
// between passes, and in RK4 mode it waits on the divide-by-six unit
// for each state in turn.
// Reset is synchronous and clears all stores; no clearing pass is needed.
// Results cannot be held off; busy stays high until the last one is out.
// ----------------------------------------------------------------------------
module state_space_integrator #(
   parameter int MAX_STATES  = ssi_pkg::MAX_STATES_DEF,
   parameter int MAX_INPUTS  = ssi_pkg::MAX_INPUTS_DEF,
   parameter int MAX_OUTPUTS = ssi_pkg::MAX_OUTPUTS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire ssi_pkg::req_item_type  req_item,
   output logic                        rsp_strobe,
   output ssi_pkg::rsp_item_type       rsp_item,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [2:0]             csr_index,
   input  wire logic [16:0]            csr_data
);
   import ssi_pkg::*;

   // configuration registers
   logic              mode_ff;
   logic [16:0]       dt_ff;
   logic [3:0]        states_ff;
   logic [2:0]        inputs_ff;
   logic [2:0]        outputs_ff;

   // clamped values seen by the sequencer and the datapath
   logic [16:0]       dt_eff;
   logic [CNT_W-1:0]  n_eff;
   logic [2:0]        m_eff;
   logic [2:0]        p_eff;

   cmd_type           cmd;
   sts_type           sts;

   // config writes must arrive only while idle (not enforced here), so accept every one at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         dt_ff      <= 17'd655;
         states_ff  <= 4'd8;
         inputs_ff  <= 3'd1;
         outputs_ff <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:    mode_ff    <= csr_data[0];
            CSR_DT:      dt_ff      <= csr_data;
            CSR_STATES:  states_ff  <= csr_data[3:0];
            CSR_INPUTS:  inputs_ff  <= csr_data[2:0];
            CSR_OUTPUTS: outputs_ff <= csr_data[2:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // saturate the register values into their usable ranges
   always_comb begin
      dt_eff = (dt_ff > 17'h10000) ? 17'h10000 : dt_ff;

      if (states_ff == 4'd0) begin
         n_eff = CNT_W'(1);
      end else if (CNT_W'(states_ff) > CNT_W'(MAX_STATES)) begin
         n_eff = CNT_W'(MAX_STATES);
      end else begin
         n_eff = CNT_W'(states_ff);
      end

      m_eff = (32'(inputs_ff) > 32'(MAX_INPUTS)) ? 3'(MAX_INPUTS) : inputs_ff;

      if (outputs_ff == 3'd0) begin
         p_eff = 3'd1;
      end else if (32'(outputs_ff) > 32'(MAX_OUTPUTS)) begin
         p_eff = 3'(MAX_OUTPUTS);
      end else begin
         p_eff = outputs_ff;
      end
   end

   // sequencer: decides the pass and the term issued each cycle
   ssi_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .action  (req_item.action),
      .mode    (mode_ff),
      .dt_zero (dt_eff == 17'd0),
      .n_used  (n_eff),
      .m_used  (m_eff),
      .p_used  (p_eff),
      .sts     (sts),
      .cmd     (cmd),
      .busy    (busy)
   );

   // datapath: stores, multiply-accumulate pipe, divider, result register
   ssi_dpath #(
      .MAX_STATES  (MAX_STATES),
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_item   (req_item),
      .dt         (dt_eff),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
`default_nettype wire

// ===== tb/ssi_model_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_model_checker : result predictor and comparator for the integrator
// Watches the request, result and configuration channels, keeps its own copy
// of the matrices, the state and the registers, predicts every result and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module ssi_model_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire ssi_pkg::req_item_type req_item,
   input  wire logic                  rsp_strobe,
   input  wire ssi_pkg::rsp_item_type rsp_item,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [2:0]            csr_index,
   input  wire logic [16:0]           csr_data,
   output int                         pending,
   output int                         fail_count
);
   import ssi_pkg::*;

   // model copy of the registers
   logic        mode_r;
   logic [16:0] dt_r;
   logic [3:0]  states_r;
   logic [2:0]  inputs_r;
   logic [2:0]  outputs_r;

   // model copy of the stores
   int a_m [8][8];
   int b_m [8][4];
   int c_m [4][8];
   int d_m [4][4];
   int x_v [8];

   // stage working arrays
   int trial_v [8];
   int rate_v  [8];
   int k1_v [8];
   int k2_v [8];
   int k3_v [8];
   int drive_v [4];

   rsp_item_type expected_outputs [$];

   initial fail_count = 0;
   initial pending = 0;

   function automatic longint fx_mul(int a, int b);
      longint pr;
      pr = longint'(a) * longint'(b);
      return pr >>> 16;
   endfunction

   function automatic int clip32(longint v);
      int r;
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = int'(v);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // rate_v = A*trial_v + B*u over the states in use
   task automatic compute_rates(input int n, input int m);
      longint acc;
      for (int i = 0; i < n; i++) begin
         acc = 0;
         for (int j = 0; j < n; j++) acc += fx_mul(a_m[i][j], trial_v[j]);
         for (int j = 0; j < m; j++) acc += fx_mul(b_m[i][j], drive_v[j]);
         rate_v[i] = clip32(acc);
      end
   endtask

   task automatic clear_model();
      mode_r = 1'b0;
      dt_r = 17'd655;
      states_r = 4'd8;
      inputs_r = 3'd1;
      outputs_r = 3'd1;
      for (int i = 0; i < 8; i++) begin
         x_v[i] = 0;
         for (int j = 0; j < 8; j++) a_m[i][j] = 0;
         for (int j = 0; j < 4; j++) b_m[i][j] = 0;
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 8; j++) c_m[i][j] = 0;
         for (int j = 0; j < 4; j++) d_m[i][j] = 0;
      end
   endtask

   task automatic predict_write(input req_item_type it);
      rsp_item_type e;
      logic ok;
      ok = 1'b1;
      case (it.target)
         TGT_A: a_m[it.row][it.column] = it.coefficient;
         TGT_B: if (it.column < 4) b_m[it.row][it.column[1:0]] = it.coefficient;
                else ok = 1'b0;
         TGT_C: if (it.row < 4) c_m[it.row[1:0]][it.column] = it.coefficient;
                else ok = 1'b0;
         TGT_D: if (it.row < 4 && it.column < 4)
                   d_m[it.row[1:0]][it.column[1:0]] = it.coefficient;
                else ok = 1'b0;
         TGT_X: x_v[it.row] = it.coefficient;
         default: ok = 1'b0;
      endcase
      e.kind = ok ? KIND_ACK : KIND_RANGE;
      e.output_index = 2'd0;
      e.output_value = 32'sd0;
      e.last = 1'b1;
      expected_outputs.push_back(e);
   endtask

   task automatic predict_step(input req_item_type it);
      int n, m, p;
      longint dt, acc, wsum, q;
      rsp_item_type e;
      n = (states_r < 1) ? 1 : (states_r > 8) ? 8 : int'(states_r);
      m = (inputs_r > 4) ? 4 : int'(inputs_r);
      p = (outputs_r < 1) ? 1 : (outputs_r > 4) ? 4 : int'(outputs_r);
      dt = (dt_r > 17'd65536) ? 65536 : longint'(dt_r);
      drive_v[0] = it.drive_0;
      drive_v[1] = it.drive_1;
      drive_v[2] = it.drive_2;
      drive_v[3] = it.drive_3;
      if (dt > 0) begin
         for (int i = 0; i < 8; i++) trial_v[i] = x_v[i];
         compute_rates(n, m);
         if (mode_r == 1'b0) begin
            for (int i = 0; i < n; i++)
               x_v[i] = clip32(longint'(x_v[i]) + ((longint'(rate_v[i]) * dt) >>> 16));
         end else begin
            // two half-step trials, one full-step trial, then the weighted sum
            for (int i = 0; i < n; i++) begin
               k1_v[i] = rate_v[i];
               trial_v[i] = clip32(longint'(x_v[i]) + ((longint'(k1_v[i]) * dt) >>> 17));
            end
            compute_rates(n, m);
            for (int i = 0; i < n; i++) begin
               k2_v[i] = rate_v[i];
               trial_v[i] = clip32(longint'(x_v[i]) + ((longint'(k2_v[i]) * dt) >>> 17));
            end
            compute_rates(n, m);
            for (int i = 0; i < n; i++) begin
               k3_v[i] = rate_v[i];
               trial_v[i] = clip32(longint'(x_v[i]) + ((longint'(k3_v[i]) * dt) >>> 16));
            end
            compute_rates(n, m);
            for (int i = 0; i < n; i++) begin
               wsum = longint'(k1_v[i]) + 2 * longint'(k2_v[i]) + 2 * longint'(k3_v[i])
                      + longint'(rate_v[i]);
               wsum = wsum * dt;
               q = wsum / 393216;
               if ((wsum % 393216) != 0 && wsum < 0) q--;
               x_v[i] = clip32(longint'(x_v[i]) + q);
            end
         end
      end
      for (int i = 0; i < p; i++) begin
         acc = 0;
         for (int j = 0; j < n; j++) acc += fx_mul(c_m[i][j], x_v[j]);
         for (int j = 0; j < m; j++) acc += fx_mul(d_m[i][j], drive_v[j]);
         e.kind = KIND_SAMPLE;
         e.output_index = i[1:0];
         e.output_value = clip32(acc);
         e.last = (i + 1 == p);
         expected_outputs.push_back(e);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         clear_model();
         expected_outputs.delete();
      end else begin
         // retire the oldest prediction before any new one is added
         if (rsp_strobe) begin
            if (expected_outputs.size() == 0) begin
               $display("unexpected result transfer at %0t", $realtime);
               fail_count++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_item.kind !== want.kind)
                  report_mismatch("kind", rsp_item.kind, want.kind);
               if (rsp_item.output_index !== want.output_index)
                  report_mismatch("output_index", rsp_item.output_index, want.output_index);
               if (rsp_item.output_value !== want.output_value)
                  report_mismatch("output_value", rsp_item.output_value, want.output_value);
               if (rsp_item.last !== want.last)
                  report_mismatch("last", rsp_item.last, want.last);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:    mode_r = csr_data[0];
               CSR_DT:      dt_r = csr_data;
               CSR_STATES:  states_r = csr_data[3:0];
               CSR_INPUTS:  inputs_r = csr_data[2:0];
               CSR_OUTPUTS: outputs_r = csr_data[2:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_item.action == ACT_WRITE) predict_write(req_item);
            else predict_step(req_item);
         end
      end
      pending <= expected_outputs.size();
   end

endmodule
`default_nettype wire

// ===== tb/tb_state_space_integrator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_state_space_integrator : stimulus and verdict for the integrator
// Loads coefficients and states, steps the model under Euler and RK4 with a
// range of register settings, and leaves prediction and comparison to the
// checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_state_space_integrator;
   import ssi_pkg::*;

   localparam int IDLE_LIMIT = 4000;   // cycles with no transfer before giving up

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   req_item_type req_item = '0;
   logic csr_valid = 1'b0;
   logic [2:0] csr_index = '0;
   logic [16:0] csr_data = '0;

   logic busy;
   logic rsp_strobe;
   rsp_item_type rsp_item;
   logic csr_ready;

   int pending;
   int fail_count;
   int idle_cycles = 0;
   int sender_idle_pct = 0;

   always #2 clock = ~clock;

   state_space_integrator dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_item(req_item),
      .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   ssi_model_checker checker_i (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_item(req_item),
      .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .pending(pending), .fail_count(fail_count)
   );

   // Watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Hold one request until it transfers, then drop start for a random gap
   task automatic send_item(input req_item_type it);
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Release start, then let every expected result arrive
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [16:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input logic md, input logic [16:0] dt, input logic [3:0] ns,
                                input logic [2:0] ni, input logic [2:0] no);
      write_csr(CSR_MODE, {16'd0, md});
      write_csr(CSR_DT, dt);
      write_csr(CSR_STATES, {13'd0, ns});
      write_csr(CSR_INPUTS, {14'd0, ni});
      write_csr(CSR_OUTPUTS, {14'd0, no});
   endtask

   function automatic req_item_type write_item(input logic [2:0] tg, input logic [2:0] r,
                                               input logic [2:0] c, input int v);
      req_item_type it;
      it = '0;
      it.action = ACT_WRITE;
      it.target = tg;
      it.row = r;
      it.column = c;
      it.coefficient = v;
      return it;
   endfunction

   function automatic req_item_type step_item(input int u0, input int u1, input int u2,
                                              input int u3);
      req_item_type it;
      it = '0;
      it.action = ACT_STEP;
      it.drive_0 = u0;
      it.drive_1 = u1;
      it.drive_2 = u2;
      it.drive_3 = u3;
      return it;
   endfunction

   // Mostly moderate values so the state stays in range, with full-width
   // and extreme values mixed in to reach saturation
   function automatic int pick_value();
      int sel;
      int v;
      sel = $urandom_range(99);
      if (sel < 78) v = int'($urandom_range(262143)) - 131072;
      else if (sel < 90) v = $urandom;
      else if (sel < 95) v = 32'sh7FFFFFFF;
      else v = 32'sh80000000;
      return v;
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      it = '0;
      it.coefficient = $urandom;
      it.drive_0 = $urandom;
      it.drive_1 = $urandom;
      it.drive_2 = $urandom;
      it.drive_3 = $urandom;
      if ($urandom_range(99) < 35) begin
         it.action = ACT_STEP;
         it.drive_0 = pick_value();
         it.drive_1 = pick_value();
         it.drive_2 = pick_value();
         it.drive_3 = pick_value();
      end else begin
         it.action = ACT_WRITE;
         it.target = ($urandom_range(99) < 88) ? 3'($urandom_range(4))
                                               : 3'($urandom_range(5, 7));
         it.row = 3'($urandom_range(7));
         it.column = 3'($urandom_range(7));
         it.coefficient = pick_value();
      end
      return it;
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: store corners, out-of-range indexes, steps at reset settings
      sender_idle_pct = 25;
      send_item(write_item(TGT_A, 3'd0, 3'd0, 32'sh7FFFFFFF));
      send_item(write_item(TGT_A, 3'd7, 3'd7, 32'sh80000000));
      send_item(write_item(TGT_A, 3'd1, 3'd0, 32'sh00008000));
      send_item(write_item(TGT_B, 3'd7, 3'd3, 32'sh00010000));
      send_item(write_item(TGT_B, 3'd0, 3'd0, 32'sh00020000));
      send_item(write_item(TGT_B, 3'd0, 3'd4, 32'sh00010000));
      send_item(write_item(TGT_C, 3'd3, 3'd7, 32'sh80000000));
      send_item(write_item(TGT_C, 3'd0, 3'd0, 32'sh00010000));
      send_item(write_item(TGT_C, 3'd4, 3'd0, 32'sh00010000));
      send_item(write_item(TGT_D, 3'd3, 3'd3, 32'sh7FFFFFFF));
      send_item(write_item(TGT_D, 3'd0, 3'd4, 32'sh00010000));
      send_item(write_item(TGT_D, 3'd4, 3'd0, 32'sh00010000));
      send_item(write_item(TGT_X, 3'd7, 3'd7, 32'sh7FFFFFFF));
      send_item(write_item(TGT_X, 3'd0, 3'd0, 32'sh00010000));
      send_item(write_item(3'd5, 3'd0, 3'd0, 32'sh00010000));
      send_item(write_item(3'd7, 3'd7, 3'd7, 32'sh80000000));
      send_item(step_item(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000));
      send_item(step_item(32'sh00010000, 0, 0, 0));
      drain();

      // Directed: RK4 at full step with every input and output
      apply_setting(1'b1, 17'd65536, 4'd8, 3'd4, 3'd4);
      send_item(step_item(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
      send_item(step_item(32'sh00010000, -32'sh00010000, 0, 32'sh00008000));
      drain();
      // Directed: zero time step and registers beyond their ranges
      apply_setting(1'b0, 17'd0, 4'd0, 3'd7, 3'd0);
      send_item(step_item(32'sh00010000, 32'sh00010000, 32'sh00010000, 32'sh00010000));
      drain();
      write_csr(3'd5, 17'h1FFFF);
      write_csr(3'd7, 17'h0);
      apply_setting(1'b1, 17'h1FFFF, 4'd15, 3'd5, 3'd7);
      send_item(step_item(32'sh00010000, 0, 32'sh80000000, 0));
      drain();

      // Random: six settings, idling profiles 25, 64 then none
      for (int seg = 0; seg < 6; seg++) begin
         sender_idle_pct = (seg < 2) ? 25 : (seg < 4) ? 64 : 0;
         case (seg)
            0: apply_setting(1'b0, 17'd655, 4'd8, 3'd1, 3'd1);
            1: apply_setting(1'b1, 17'd1, 4'd1, 3'd0, 3'd4);
            2: apply_setting(1'b1, 17'd8192, 4'd3, 3'd2, 3'd2);
            3: apply_setting(1'b0, 17'd65536, 4'd9, 3'd6, 3'd5);
            4: apply_setting(1'b1, 17'($urandom_range(1, 65536)), 4'($urandom_range(1, 8)),
                             3'($urandom_range(4)), 3'($urandom_range(1, 4)));
            default: apply_setting(1'b0, 17'($urandom_range(1, 65536)),
                                   4'($urandom_range(1, 8)), 3'($urandom_range(4)),
                                   3'($urandom_range(1, 4)));
         endcase
         for (int k = 0; k < 33; k++) send_item(random_item());
         drain();
      end

      // Settle any trailing activity before the verdict
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/ssi_pkg.sv
hdl/ssi_div6.sv
hdl/ssi_ctrl.sv
hdl/ssi_dpath.sv
hdl/state_space_integrator.sv
tb/ssi_model_checker.sv
tb/tb_state_space_integrator.sv
